// ----- rtl/deq_pkg.sv -----
// Shared types, constants and ring helpers for the bounded deque with search.
package deq_pkg;

  // Store geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed port field widths
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH     = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      found;
    logic [POS_W-1:0]          position;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } out_item_t;

  typedef struct packed {
    op_t                   op;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  // Ring index base + off, with off no greater than the depth
  function automatic logic [ADDR_W-1:0] ring_add(logic [ADDR_W-1:0] base,
                                                 logic [ADDR_W:0]   off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Ring index one step toward the front
  function automatic logic [ADDR_W-1:0] ring_dec(logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] res;
    if (base == '0) begin
      res = ADDR_W'(DEPTH - 1);
    end else begin
      res = base - ADDR_W'(1);
    end
    return res;
  endfunction

endpackage

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/deq_front.sv -----
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
module deq_front import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_req,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  logic [1:0] fill_r, fill_nxt;
  cmd_t       slot0_r, slot0_nxt;
  cmd_t       slot1_r, slot1_nxt;
  cmd_t       new_cmd;
  logic       push;

  // Classify the incoming request
  always_comb begin
    new_cmd.value = DATA_WIDTH'(in_req.value_in);
    unique case (in_req.func)
      FUNC_PUSH_FRONT: new_cmd.op = OP_PUSH_FRONT;
      FUNC_PUSH_BACK:  new_cmd.op = OP_PUSH_BACK;
      FUNC_POP_FRONT:  new_cmd.op = OP_POP_FRONT;
      FUNC_POP_BACK:   new_cmd.op = OP_POP_BACK;
      FUNC_SEARCH:     new_cmd.op = OP_SEARCH;
      default:         new_cmd.op = OP_NOP;
    endcase
  end

  assign busy      = (fill_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = slot0_r;

  // Advance the queue: slot0 is always the oldest request
  always_comb begin
    fill_nxt  = fill_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    unique case (fill_r)
      2'd0: begin
        if (push) begin
          slot0_nxt = new_cmd;
          fill_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && cmd_pop) begin
          slot0_nxt = new_cmd;
        end else if (push) begin
          slot1_nxt = new_cmd;
          fill_nxt  = 2'd2;
        end else if (cmd_pop) begin
          fill_nxt = 2'd0;
        end
      end
      default: begin
        if (cmd_pop) begin
          slot0_nxt = slot1_r;
          fill_nxt  = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ----- rtl/deq_back.sv -----
// Back end: executes queued requests on the ring store and registers each result.
module deq_back import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  output out_item_t out_res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_POP    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]     off_r, off_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_res_r, out_res_nxt;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [DATA_WIDTH-1:0] rd_data;
  out_item_t             res;

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Sequence one request at a time
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    off_nxt       = off_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    cmd_pop       = 1'b0;
    we            = 1'b0;
    waddr         = head_r;
    raddr         = head_r;
    res           = '0;
    res.status    = STATUS_OK;
    res.count     = COUNT_W'(count_r);

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res.status = STATUS_FULL;
              end else begin
                we = 1'b1;
                if (cmd.op == OP_PUSH_FRONT) begin
                  waddr    = ring_dec(head_r);
                  head_nxt = ring_dec(head_r);
                end else begin
                  waddr = ring_add(head_r, (ADDR_W+1)'(count_r));
                end
                count_nxt = count_r + CNT_W'(1);
                res.count = COUNT_W'(count_nxt);
              end
              out_valid_nxt = 1'b1;
              out_res_nxt   = res;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_r == '0) begin
                res.status    = STATUS_EMPTY;
                out_valid_nxt = 1'b1;
                out_res_nxt   = res;
              end else begin
                if (cmd.op == OP_POP_FRONT) begin
                  raddr    = head_r;
                  head_nxt = ring_add(head_r, (ADDR_W+1)'(1));
                end else begin
                  raddr = ring_add(head_r, (ADDR_W+1)'(count_r - CNT_W'(1)));
                end
                count_nxt = count_r - CNT_W'(1);
                state_nxt = ST_POP;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt   = res;
              end else begin
                raddr     = head_r;
                key_nxt   = cmd.value;
                off_nxt   = '0;
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_res_nxt   = res;
            end
          endcase
        end
      end
      ST_POP: begin
        // read data of the popped slot is ready now
        res.value_out = VALUE_W'(rd_data);
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
        state_nxt     = ST_IDLE;
      end
      ST_SEARCH: begin
        // compare one slot per cycle while fetching the next
        raddr   = ring_add(head_r, (ADDR_W+1)'(off_r) + (ADDR_W+1)'(1));
        off_nxt = off_r + ADDR_W'(1);
        if (rd_data == key_r) begin
          res.found     = 1'b1;
          res.position  = POS_W'(off_r);
          out_valid_nxt = 1'b1;
          out_res_nxt   = res;
          state_nxt     = ST_IDLE;
        end else if (CNT_W'(off_r) + CNT_W'(1) == count_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r     <= key_nxt;
    off_r     <= off_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- rtl/bounded_deque_with_search_unit.sv -----
// Push, error and unknown requests and a search of an empty deque are answered from idle; a pop
// waits in the pop state for read data; a search reads slots through the single read port of
// the ring store until a hit or the last slot. Back end throughput: one push per cycle while no
// pop or search is in progress, which holds off new requests; a two-entry request queue covers gaps.
// Synchronous active-low reset empties the deque and queue; stored slot contents stay.
// Each result is shown for one cycle under out_valid and cannot be held off.
module bounded_deque_with_search_unit import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_req,
  output logic      out_valid,
  output out_item_t out_res
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  deq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the bounded deque with search unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_LAST = 3'd7;
  localparam int N_ITEMS  = 1600;
  localparam int N_REPORT = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    in_item_t req;
    bit       hold;  // wait until all outstanding results are back
  } stim_t;

  typedef enum {WALK_MIX, WALK_GROW, WALK_SHRINK} walk_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_req = '0;
  logic      out_valid;
  out_item_t out_res;

  stim_t     pending[$];
  out_item_t expected[$];

  // Predictor state: ring contents, front index and occupancy
  logic signed [VALUE_W-1:0] slot_mem [DEPTH];
  int        front_idx = 0;
  int        held = 0;

  bit        took = 1'b0;
  int        sent = 0;
  int        errors = 0;
  int        checked = 0;
  int        n_full = 0;
  int        n_empty = 0;
  int        n_hit = 0;
  int        peak = 0;
  int        stall_cycles = 0;

  logic signed [VALUE_W-1:0] value_pool [8] = '{
    32'sh0, -32'sd1, 32'sh80000000, 32'sh7fffffff,
    32'sd1, 32'sh55555555, 32'shaaaaaaaa, 32'sd1234
  };

  bounded_deque_with_search_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one request and advance the deque state
  function automatic out_item_t deque_predict(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (req.func == FUNC_PUSH_FRONT) begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          slot_mem[front_idx] = req.value_in;
          held++;
        end else begin
          slot_mem[(front_idx + held) % DEPTH] = req.value_in;
          held++;
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (held == 0) begin
          res.status = STATUS_EMPTY;
        end else if (req.func == FUNC_POP_FRONT) begin
          res.value_out = slot_mem[front_idx];
          front_idx = (front_idx + 1) % DEPTH;
          held--;
        end else begin
          res.value_out = slot_mem[(front_idx + held - 1) % DEPTH];
          held--;
        end
      end
      FUNC_SEARCH: begin
        for (int i = 0; i < held; i++) begin
          if (!res.found && slot_mem[(front_idx + i) % DEPTH] == req.value_in) begin
            res.found = 1'b1;
            res.position = POS_W'(i);
          end
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(held);
    return res;
  endfunction

  // Mostly values from a small pool so searches hit and duplicates occur
  function automatic logic signed [VALUE_W-1:0] rand_value();
    if ($urandom_range(0, 99) < 60) begin
      return value_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  task automatic queue_req(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value,
                           bit hold = 1'b0);
    stim_t s;
    s.req.func = func;
    s.req.value_in = value;
    s.hold = hold;
    pending.push_back(s);
  endtask

  // Sender idle percentage for the current third of the run
  function automatic int idle_pct();
    if (sent < N_ITEMS / 3) begin
      return 31;
    end else if (sent < 2 * N_ITEMS / 3) begin
      return 86;
    end
    return 0;
  endfunction

  // Drive requests on the falling edge; hold a request until it is taken
  always @(negedge clk) begin
    stim_t nxt;
    if (rst_n && (!start || took)) begin
      if (pending.size() > 0 && !(pending[0].hold && expected.size() > 0) &&
          $urandom_range(0, 99) >= idle_pct()) begin
        nxt = pending.pop_front();
        in_req <= nxt.req;
        start  <= 1'b1;
        sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check results and predict accepted requests on the rising edge
  always @(posedge clk) begin
    out_item_t exp_res;
    out_item_t pred;
    took <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (expected.size() == 0) begin
          errors++;
          if (errors <= N_REPORT) begin
            $display("%0t: result with no request outstanding: %p", $realtime, out_res);
          end
        end else begin
          exp_res = expected.pop_front();
          checked++;
          if (out_res.value_out !== exp_res.value_out || out_res.found !== exp_res.found ||
              out_res.position !== exp_res.position || out_res.status !== exp_res.status ||
              out_res.count !== exp_res.count) begin
            errors++;
            if (errors <= N_REPORT) begin
              $display("%0t: mismatch expected %p actual %p", $realtime, exp_res, out_res);
            end
          end
        end
      end
      if (start && !busy) begin
        pred = deque_predict(in_req);
        expected.push_back(pred);
        if (pred.status == STATUS_FULL) n_full++;
        if (pred.status == STATUS_EMPTY) n_empty++;
        if (pred.found) n_hit++;
        if (held > peak) peak = held;
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Build the request list, run it, then report
  initial begin
    walk_t walk;
    int    walk_left;
    int    gen_cnt;
    int    r;
    int    n_dir;
    logic [FUNC_W-1:0] f;

    // Directed: empty-queue errors, unknown codes, extremes, duplicates, misses
    queue_req(FUNC_POP_FRONT, 32'sd0);
    queue_req(FUNC_POP_BACK, -32'sd1);
    queue_req(FUNC_SEARCH, 32'sd0);
    for (int k = int'(FUNC_SEARCH) + 1; k <= int'(FUNC_LAST); k++) begin
      queue_req(FUNC_W'(k), $urandom);
    end
    queue_req(FUNC_PUSH_FRONT, 32'sh80000000);
    queue_req(FUNC_PUSH_BACK, 32'sh7fffffff);
    queue_req(FUNC_PUSH_FRONT, 32'sh0);
    queue_req(FUNC_PUSH_BACK, -32'sd1);
    queue_req(FUNC_PUSH_FRONT, 32'sh80000000);
    queue_req(FUNC_SEARCH, 32'sh80000000);
    queue_req(FUNC_SEARCH, -32'sd1);
    queue_req(FUNC_SEARCH, 32'sh7fffffff);
    queue_req(FUNC_SEARCH, 32'sd12345);
    queue_req(FUNC_POP_BACK, 32'sd0);
    queue_req(FUNC_POP_FRONT, 32'sd0);
    queue_req(FUNC_POP_FRONT, 32'sd0);
    queue_req(FUNC_POP_BACK, 32'sd0);
    queue_req(FUNC_POP_BACK, 32'sd0);
    queue_req(FUNC_POP_FRONT, 32'sd0);
    n_dir = pending.size();

    // Random: occupancy walks between growth and shrink so the full and
    // empty corners are hit repeatedly with random contents
    gen_cnt = 0;
    walk = WALK_GROW;
    walk_left = 0;
    for (int k = n_dir; k < N_ITEMS; k++) begin
      if (walk_left == 0) begin
        walk = walk_t'($urandom_range(0, 2));
        walk_left = $urandom_range(20, 60);
      end
      walk_left--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        f = FUNC_W'($urandom_range(int'(FUNC_SEARCH) + 1, int'(FUNC_LAST)));
      end else begin
        r = $urandom_range(0, 99);
        case (walk)
          WALK_GROW:   f = (r < 65) ? FUNC_PUSH_FRONT : (r < 80) ? FUNC_POP_FRONT : FUNC_SEARCH;
          WALK_SHRINK: f = (r < 15) ? FUNC_PUSH_FRONT : (r < 80) ? FUNC_POP_FRONT : FUNC_SEARCH;
          default:     f = (r < 36) ? FUNC_PUSH_FRONT : (r < 72) ? FUNC_POP_FRONT : FUNC_SEARCH;
        endcase
        // Pick the end at random
        if (f != FUNC_SEARCH && $urandom_range(0, 1)) begin
          f = (f == FUNC_PUSH_FRONT) ? FUNC_PUSH_BACK : FUNC_POP_BACK;
        end
      end
      if ((f == FUNC_PUSH_FRONT || f == FUNC_PUSH_BACK) && gen_cnt < DEPTH) gen_cnt++;
      if ((f == FUNC_POP_FRONT || f == FUNC_POP_BACK) && gen_cnt > 0) gen_cnt--;
      queue_req(f, rand_value(),
                k == n_dir || k == N_ITEMS / 3 || k == 2 * N_ITEMS / 3);
    end

    // Release reset on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for all requests to be taken and all results to come back
    while (pending.size() != 0 || start || expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked: %0d full drops, %0d empty pops,",
             sent, checked, n_full, n_empty);
    $display("%0d search hits, peak occupancy %0d of %0d, %0d mismatches",
             n_hit, peak, DEPTH, errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/bounded_deque_with_search_unit.sv
dv/tb.sv
